@@ design/bbs_pkg.sv @@
// shared types and constants for the bollinger band stream
// no dependencies
`default_nettype none

package bbs_pkg;

  localparam int unsigned LEN_W    = 9;
  localparam int unsigned MULT_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned BAND_W   = 32;
  localparam int unsigned VAR_W    = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned PROD_W   = ROOT_W + MULT_W;
  localparam int unsigned FRAC_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_MULTIPLIER = 2'd1;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 9'd20;
  localparam logic [MULT_W-1:0] MULT_RESET = 16'd8192;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SUM  = 9'b000000010,
    ST_MDIV = 9'b000000100,
    ST_SQ   = 9'b000001000,
    ST_VDIV = 9'b000010000,
    ST_SQRT = 9'b000100000,
    ST_MUL  = 9'b001000000,
    ST_BAND = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

@@ design/bbs_div.sv @@
// restoring divider, one quotient bit per cycle, unsigned
// no package dependencies
`default_nettype none

module bbs_div #(
  parameter int unsigned DW = 65,
  parameter int unsigned NW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [NW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [NW-1:0]   rem_q;
  logic [NW:0]     rem_sh;
  logic [NW+1:0]   trial;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign ge     = !trial[NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? trial[NW-1:0] : rem_sh[NW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ design/bbs_isqrt.sv @@
// integer square root of a 64-bit value, two bits per cycle
// uses bbs_pkg for widths
`default_nettype none

module bbs_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bbs_pkg::VAR_W-1:0]   value_i,
  output logic                             done_o,
  output logic [bbs_pkg::ROOT_W-1:0]       root_o
);

  localparam int unsigned VW = bbs_pkg::VAR_W;

  logic          busy_q, done_q;
  logic [VW-1:0] v_q, res_q, bit_q;
  logic [VW-1:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= VW'(1) << (VW - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[bbs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ design/bollinger_band_stream.sv @@
// bollinger band stream top level: window store, sequencer, band output register
// uses bbs_pkg, bbs_div, bbs_isqrt
// window not yet full: zero bands, bands_valid low; full window of n samples: a walk sums
// the window, the shared divider gives the mean, a second walk sums squared deviations,
// the divider gives the variance, then root, multiply and bands; one item at a time;
// DW = max(2*SAMPLE_BITS + clog2(WINDOW_MAX) + 2, 65); stalled results hold the input off
`default_nettype none

module bollinger_band_stream #(
  parameter int unsigned WINDOW_MAX  = 256,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bbs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bbs_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [bbs_pkg::IN_W-1:0]   sample_i,
  input  wire logic                              series_start_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   bands_valid_o,
  output logic signed [bbs_pkg::BAND_W-1:0]      middle_band_o,
  output logic signed [bbs_pkg::BAND_W-1:0]      upper_band_o,
  output logic signed [bbs_pkg::BAND_W-1:0]      lower_band_o
);

  localparam int unsigned AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned SUMW = SB + AW + 1;
  localparam int unsigned ACCW = 2 * SB + AW + 2;
  localparam int unsigned DW   = (ACCW > 65) ? ACCW : 65;
  localparam int unsigned SQW  = 2 * SB + 2;
  localparam int unsigned BW   = SB + 40;
  localparam int unsigned VW   = bbs_pkg::VAR_W;
  localparam int unsigned PW   = bbs_pkg::PROD_W;
  localparam logic signed [BW-1:0] BAND_MAX = BW'(32'h7fffffff);
  localparam logic signed [BW-1:0] BAND_MIN = -BAND_MAX - BW'(1);

  function automatic logic [bbs_pkg::BAND_W-1:0] sat_band(input logic signed [BW-1:0] v);
    logic [bbs_pkg::BAND_W-1:0] r;
    if (v > BAND_MAX) begin
      r = BAND_MAX[bbs_pkg::BAND_W-1:0];
    end else if (v < BAND_MIN) begin
      r = BAND_MIN[bbs_pkg::BAND_W-1:0];
    end else begin
      r = v[bbs_pkg::BAND_W-1:0];
    end
    return r;
  endfunction

  bbs_pkg::state_e state_q, state_d;

  logic [bbs_pkg::LEN_W-1:0]  len_q;
  logic [bbs_pkg::MULT_W-1:0] mult_q;
  logic [AW-1:0]              wpos_q, wpos_d;
  logic [CW-1:0]              seen_q, seen_d;
  logic [AW-1:0]              rd_addr_q, rd_addr_d;
  logic [CW-1:0]              iss_cnt_q, iss_cnt_d;
  logic                       v1_q, v2_q;
  logic signed [SB-1:0]       mem [WINDOW_MAX];
  logic signed [SB-1:0]       rdata_q;
  logic signed [SUMW-1:0]     sum_q, sum_d;
  logic [ACCW-1:0]            acc_q, acc_d;
  logic [SQW-1:0]             sq_q;
  logic signed [SB-1:0]       mean_q, mean_d;
  logic [bbs_pkg::ROOT_W-1:0] dev_q;
  logic [PW-1:0]              prod_q;
  logic                       res_full_q, res_full_d;
  logic [bbs_pkg::BAND_W-1:0] res_mid_q, res_mid_d, res_up_q, res_up_d, res_lo_q, res_lo_d;
  logic                       out_valid_q;
  logic [bbs_pkg::BAND_W-1:0] out_mid_q, out_up_q, out_lo_q;
  logic                       out_full_q;

  logic [CW-1:0]          n_eff;
  logic                   accept, issue, out_load;
  logic [AW-1:0]          base_wpos, wpos_next, rd_prev;
  logic [CW-1:0]          base_seen, seen_next;
  logic [SB+31:0]         raw_w;
  logic signed [SB-1:0]   sample_sx;
  logic [SUMW-1:0]        sum_mag;
  logic signed [SB:0]     diff;
  logic [SB:0]            diff_mag;
  logic                   div_start, div_done, sqrt_start, sqrt_done;
  logic [DW-1:0]          div_dividend, div_quot;
  logic [VW-1:0]          var_sat;
  logic [bbs_pkg::ROOT_W-1:0] root;
  logic signed [BW-1:0]   mean_w, scaled_w;

  always_comb begin
    if (len_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(len_q) > WINDOW_MAX) begin
      n_eff = CW'(WINDOW_MAX);
    end else begin
      n_eff = CW'(len_q);
    end
  end

  assign raw_w     = {{SB{1'b0}}, sample_i};
  assign sample_sx = raw_w[SB-1:0];

  assign accept     = in_valid_i && (state_q == bbs_pkg::ST_IDLE);
  assign in_stall_o = (state_q != bbs_pkg::ST_IDLE);

  assign base_wpos = series_start_i ? '0 : wpos_q;
  assign base_seen = series_start_i ? '0 : seen_q;
  assign wpos_next = (base_wpos == AW'(WINDOW_MAX - 1)) ? '0 : base_wpos + 1'b1;
  assign seen_next = (base_seen < CW'(WINDOW_MAX)) ? base_seen + 1'b1 : base_seen;

  assign issue   = ((state_q == bbs_pkg::ST_SUM) || (state_q == bbs_pkg::ST_SQ)) &&
                   (iss_cnt_q != n_eff);
  assign rd_prev = (rd_addr_q == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_q - 1'b1;

  assign sum_mag      = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign div_dividend = (state_q == bbs_pkg::ST_SUM) ? DW'(sum_mag) : DW'(acc_q);
  assign var_sat      = (|div_quot[DW-1:VW]) ? '1 : div_quot[VW-1:0];

  assign diff     = (SB+1)'(rdata_q) - (SB+1)'(mean_q);
  assign diff_mag = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);

  assign mean_w   = BW'(mean_q);
  assign scaled_w = $signed(BW'(prod_q[PW-1:bbs_pkg::FRAC_W]));

  assign out_load = (state_q == bbs_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    wpos_d     = wpos_q;
    seen_d     = seen_q;
    rd_addr_d  = rd_addr_q;
    iss_cnt_d  = iss_cnt_q;
    sum_d      = sum_q;
    acc_d      = acc_q;
    mean_d     = mean_q;
    res_full_d = res_full_q;
    res_mid_d  = res_mid_q;
    res_up_d   = res_up_q;
    res_lo_d   = res_lo_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    if (issue) begin
      rd_addr_d = rd_prev;
      iss_cnt_d = iss_cnt_q + 1'b1;
    end
    case (state_q)
      bbs_pkg::ST_IDLE: begin
        if (accept) begin
          wpos_d = wpos_next;
          seen_d = seen_next;
          if (seen_next >= n_eff) begin
            state_d   = bbs_pkg::ST_SUM;
            iss_cnt_d = '0;
            rd_addr_d = wpos_next;
            sum_d     = '0;
          end else begin
            state_d    = bbs_pkg::ST_DONE;
            res_full_d = 1'b0;
            res_mid_d  = '0;
            res_up_d   = '0;
            res_lo_d   = '0;
          end
        end
      end
      bbs_pkg::ST_SUM: begin
        if (v1_q) begin
          sum_d = sum_q + SUMW'(rdata_q);
        end
        if (!issue && !v1_q) begin
          div_start = 1'b1;
          state_d   = bbs_pkg::ST_MDIV;
        end
      end
      bbs_pkg::ST_MDIV: begin
        if (div_done) begin
          mean_d    = sum_q[SUMW-1] ? -$signed(div_quot[SB-1:0]) : $signed(div_quot[SB-1:0]);
          state_d   = bbs_pkg::ST_SQ;
          iss_cnt_d = '0;
          rd_addr_d = wpos_q;
          acc_d     = '0;
        end
      end
      bbs_pkg::ST_SQ: begin
        if (v2_q) begin
          acc_d = acc_q + ACCW'(sq_q);
        end
        if (!issue && !v1_q && !v2_q) begin
          div_start = 1'b1;
          state_d   = bbs_pkg::ST_VDIV;
        end
      end
      bbs_pkg::ST_VDIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = bbs_pkg::ST_SQRT;
        end
      end
      bbs_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_d = bbs_pkg::ST_MUL;
        end
      end
      bbs_pkg::ST_MUL: begin
        state_d = bbs_pkg::ST_BAND;
      end
      bbs_pkg::ST_BAND: begin
        res_full_d = 1'b1;
        res_mid_d  = sat_band(mean_w);
        res_up_d   = sat_band(mean_w + scaled_w);
        res_lo_d   = sat_band(mean_w - scaled_w);
        state_d    = bbs_pkg::ST_DONE;
      end
      bbs_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = bbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbs_pkg::ST_IDLE;
      len_q       <= bbs_pkg::LEN_RESET;
      mult_q      <= bbs_pkg::MULT_RESET;
      wpos_q      <= '0;
      seen_q      <= '0;
      iss_cnt_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wpos_q    <= wpos_d;
      seen_q    <= seen_d;
      iss_cnt_q <= iss_cnt_d;
      v1_q      <= issue;
      v2_q      <= v1_q && (state_q == bbs_pkg::ST_SQ);
      if (cfg_we_i && (cfg_idx_i == bbs_pkg::REG_WINDOW_LENGTH)) begin
        len_q <= cfg_data_i[bbs_pkg::LEN_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == bbs_pkg::REG_BAND_MULTIPLIER)) begin
        mult_q <= cfg_data_i[bbs_pkg::MULT_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[base_wpos] <= sample_sx;
    end
    if (issue) begin
      rdata_q <= mem[rd_prev];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    sum_q      <= sum_d;
    acc_q      <= acc_d;
    mean_q     <= mean_d;
    sq_q       <= SQW'(diff_mag) * SQW'(diff_mag);
    res_full_q <= res_full_d;
    res_mid_q  <= res_mid_d;
    res_up_q   <= res_up_d;
    res_lo_q   <= res_lo_d;
    if (sqrt_done) begin
      dev_q <= root;
    end
    if (state_q == bbs_pkg::ST_MUL) begin
      prod_q <= PW'(dev_q) * PW'(mult_q);
    end
    if (out_load) begin
      out_full_q <= res_full_q;
      out_mid_q  <= res_mid_q;
      out_up_q   <= res_up_q;
      out_lo_q   <= res_lo_q;
    end
  end

  bbs_div #(
    .DW (DW),
    .NW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  bbs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (var_sat),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign out_valid_o   = out_valid_q;
  assign bands_valid_o = out_full_q;
  assign middle_band_o = out_mid_q;
  assign upper_band_o  = out_up_q;
  assign lower_band_o  = out_lo_q;

endmodule

`default_nettype wire

@@ design/bbs_checker.sv @@
// port-level checks for bollinger_band_stream, attached by bind
// depends only on the top level port list
`default_nettype none

module bbs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               bands_valid_o,
  input wire logic signed [31:0] middle_band_o,
  input wire logic signed [31:0] upper_band_o,
  input wire logic signed [31:0] lower_band_o
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous item in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(middle_band_o))
    else $error("stalled result dropped or changed");

  a_not_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bands_valid_o |->
      middle_band_o == 0 && upper_band_o == 0 && lower_band_o == 0)
    else $error("bands not zero before window fills");

  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bands_valid_o |->
      upper_band_o >= middle_band_o && lower_band_o <= middle_band_o)
    else $error("band ordering broken");

endmodule

bind bollinger_band_stream bbs_checker u_bbs_checker (.*);

`default_nettype wire

@@ tb/tb_bollinger_band_stream.sv @@
// self-checking testbench for bollinger_band_stream: directed table, then random price phases
// predicts each result with its own model of the window, mean, deviation and bands
// depends on bbs_pkg and bollinger_band_stream
`default_nettype none

module tb_bollinger_band_stream;

  localparam int unsigned WIN_MAX = 256;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLDOFF_CYCLES = 3000;
  localparam logic [bbs_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [bbs_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  typedef struct packed {
    logic bands_valid;
    logic signed [31:0] middle;
    logic signed [31:0] upper;
    logic signed [31:0] lower;
  } bands_t;

  typedef struct {
    bit is_cfg;
    logic [bbs_pkg::CFG_IDX_W-1:0] idx;
    logic [bbs_pkg::CFG_W-1:0] data;
    logic signed [31:0] smp;
    bit start;
    bit typed;
    bands_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [bbs_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [bbs_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] sample = '0;
  logic series_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic bands_valid;
  logic signed [31:0] middle_band, upper_band, lower_band;

  bollinger_band_stream dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .sample_i(sample), .series_start_i(series_start),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .bands_valid_o(bands_valid), .middle_band_o(middle_band),
    .upper_band_o(upper_band), .lower_band_o(lower_band)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] price_window [WIN_MAX];
  int unsigned wr_pos = 0;
  int unsigned held = 0;
  logic [8:0] len_reg = bbs_pkg::LEN_RESET;
  logic [15:0] mult_reg = bbs_pkg::MULT_RESET;

  bands_t pending_bands [$];
  row_t table_rows [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_got = 0;
  int unsigned full_results = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit valid_up = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return S_MAX;
    if (v < -64'sd2147483648) return S_MIN;
    return v[31:0];
  endfunction

  function automatic bands_t predict_bands(logic signed [31:0] s, bit start);
    int unsigned n, p;
    longint sum, mean, scaled, d;
    logic [63:0] ad, var_q, dev;
    logic [127:0] sq, q;
    bands_t r;
    r = '0;
    if (start) begin
      held = 0;
      wr_pos = 0;
    end
    price_window[wr_pos] = s;
    wr_pos = (wr_pos + 1) % WIN_MAX;
    if (held < WIN_MAX) held++;
    n = (len_reg == 0) ? 1 : (len_reg > WIN_MAX) ? WIN_MAX : len_reg;
    if (held < n) return r;
    sum = 0;
    p = wr_pos;
    for (int i = 0; i < n; i++) begin
      p = (p + WIN_MAX - 1) % WIN_MAX;
      sum += price_window[p];
    end
    mean = sum / longint'(n);
    sq = 0;
    p = wr_pos;
    for (int i = 0; i < n; i++) begin
      p = (p + WIN_MAX - 1) % WIN_MAX;
      d = price_window[p] - mean;
      ad = (d < 0) ? -d : d;
      sq += {64'd0, ad} * {64'd0, ad};
    end
    q = sq / 128'(n);
    var_q = (q[127:64] != 0) ? '1 : q[63:0];
    dev = root64(var_q);
    scaled = longint'((dev * 64'(mult_reg)) >> bbs_pkg::FRAC_W);
    r.bands_valid = 1'b1;
    r.middle = sat32(mean);
    r.upper = sat32(mean + scaled);
    r.lower = sat32(mean - scaled);
    return r;
  endfunction

  task automatic put_item(logic signed [31:0] s, bit start, bit typed, bands_t want);
    bands_t p;
    in_valid <= 1'b1;
    sample <= s;
    series_start <= start;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    p = predict_bands(s, start);
    pending_bands.push_back(typed ? want : p);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [bbs_pkg::CFG_IDX_W-1:0] idx, logic [bbs_pkg::CFG_W-1:0] data);
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (pending_bands.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == bbs_pkg::REG_WINDOW_LENGTH) len_reg = data[8:0];
    else if (idx == bbs_pkg::REG_BAND_MULTIPLIER) mult_reg = data;
  endtask

  function automatic void row_cfg(logic [bbs_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bbs_pkg::CFG_W-1:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    table_rows.push_back(r);
  endfunction

  function automatic void row_item(logic signed [31:0] s, bit start, bit typed, bands_t want);
    row_t r;
    r = '{default: '0};
    r.smp = s;
    r.start = start;
    r.typed = typed;
    r.want = want;
    table_rows.push_back(r);
  endfunction

  // receiver stall pattern, with one long hold-off
  int unsigned stall_mode = 0, mode_left = 0, holdoff_left = 0;
  bit holdoff_done = 1'b0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    if (!holdoff_done && results_got >= 400) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    bands_t w;
    if (rst_ni && out_valid && !out_stall) begin
      results_got++;
      if (pending_bands.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        w = pending_bands.pop_front();
        if (w.bands_valid) full_results++;
        if (bands_valid !== w.bands_valid) begin
          $error("bands_valid expected %0d got %0d", w.bands_valid, bands_valid);
          fail_count++;
        end
        if (middle_band !== w.middle) begin
          $error("middle_band expected %0d got %0d", w.middle, middle_band);
          fail_count++;
        end
        if (upper_band !== w.upper) begin
          $error("upper_band expected %0d got %0d", w.upper, upper_band);
          fail_count++;
        end
        if (lower_band !== w.lower) begin
          $error("lower_band expected %0d got %0d", w.lower, lower_band);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    bands_t z, w;
    int unsigned lens [8] = '{4, 20, 1, 256, 7, 0, 400, 12};
    int unsigned counts [8] = '{110, 120, 90, 300, 110, 60, 110, 150};
    logic signed [31:0] base, s;
    int unsigned k;
    z = '0;

    row_item(S_MAX, 1'b0, 1'b1, z);
    row_item(S_MIN, 1'b0, 1'b1, z);
    row_item(32'sd0, 1'b1, 1'b1, z);
    row_cfg(bbs_pkg::REG_WINDOW_LENGTH, 16'd1);
    row_item(S_MAX, 1'b0, 1'b1, '{1'b1, S_MAX, S_MAX, S_MAX});
    row_item(S_MIN, 1'b0, 1'b1, '{1'b1, S_MIN, S_MIN, S_MIN});
    row_cfg(bbs_pkg::REG_BAND_MULTIPLIER, 16'hffff);
    row_cfg(bbs_pkg::REG_WINDOW_LENGTH, 16'd2);
    row_item(S_MAX, 1'b1, 1'b1, z);
    row_item(S_MIN, 1'b0, 1'b0, z);
    row_item(S_MAX, 1'b0, 1'b0, z);
    row_item(S_MAX, 1'b0, 1'b0, z);
    row_item(-32'sd1, 1'b0, 1'b0, z);
    row_cfg(bbs_pkg::REG_WINDOW_LENGTH, 16'd0);
    row_item(32'sd5, 1'b0, 1'b1, '{1'b1, 32'sd5, 32'sd5, 32'sd5});
    row_cfg(bbs_pkg::REG_WINDOW_LENGTH, 16'h01ff);
    row_item(32'sd7, 1'b1, 1'b1, z);
    row_cfg(REG_SPARE_2, 16'hffff);
    row_cfg(REG_SPARE_3, 16'hffff);
    row_cfg(bbs_pkg::REG_BAND_MULTIPLIER, 16'd0);
    row_cfg(bbs_pkg::REG_WINDOW_LENGTH, 16'd3);
    row_item(-32'sd1, 1'b1, 1'b1, z);
    row_item(32'sd1, 1'b0, 1'b1, z);
    row_item(32'sh00010000, 1'b0, 1'b0, z);
    row_cfg(bbs_pkg::REG_BAND_MULTIPLIER, 16'd4096);
    row_item(-32'sh00010000, 1'b0, 1'b0, z);
    row_item(32'sh55555555, 1'b0, 1'b0, z);
    row_item(32'shaaaaaaaa, 1'b0, 1'b0, z);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) write_reg(table_rows[i].idx, table_rows[i].data);
      else put_item(table_rows[i].smp, table_rows[i].start, table_rows[i].typed,
                    table_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(bbs_pkg::REG_WINDOW_LENGTH, 16'(lens[ph]));
      case (ph % 4)
        0: w.middle = 0;
        1: w.middle = 65535;
        default: w.middle = $urandom_range(0, 65535);
      endcase
      write_reg(bbs_pkg::REG_BAND_MULTIPLIER, w.middle[15:0]);
      base = $urandom;
      for (int i = 0; i < counts[ph]; i++) begin
        k = $urandom_range(0, 9);
        if (k <= 5) begin
          base = base + $signed($urandom_range(0, 8191)) - 4096;
          s = base + $signed($urandom_range(0, 262143)) - 131072;
        end else if (k <= 7) begin
          s = $urandom;
        end else if (k == 8) begin
          s = $urandom_range(0, 1) ? S_MAX : S_MIN;
        end else begin
          s = -base;
        end
        put_item(s, (i == 0) || ($urandom_range(0, 99) == 0), 1'b0, z);
      end
    end

    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (pending_bands.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);

    $display("covered %0d samples over 8 window and multiplier settings plus directed cases",
             items_sent);
    $display("%0d results checked, %0d with a full window", results_got, full_results);
    if (fail_count == 0 && pending_bands.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
